/* src/csac_pkg.sv */
`default_nettype none

package csac_pkg;

  localparam int unsigned CROSSING_LIMIT = 10;
  localparam logic [7:0]  StartupDelayReset = 8'd19;

  localparam logic signed [16:0] LpfNewQ16  = 17'sd62259;
  localparam logic signed [13:0] LpfOldQ16  = 14'sd3277;
  localparam logic signed [41:0] LpfRound   = 42'sd32768;
  localparam logic [18:0]        StepQ32    = 19'd429497;
  localparam logic [47:0]        StepRound  = 48'h0000_8000_0000;
  localparam logic [7:0]         Div10Mul   = 8'd205;
  localparam int unsigned        Div10Shift = 11;
  localparam logic [28:0]        OffsetLo   = 29'd16777216;
  localparam logic [28:0]        OffsetHi   = 29'd33554432;
  localparam logic [28:0]        ScaleLo    = 29'd167772160;
  localparam logic [28:0]        ScaleHi    = 29'd218103808;

  typedef enum logic [2:0] {
    ST_SKIPPED   = 3'd0,
    ST_CHANGED   = 3'd1,
    ST_INACTIVE  = 3'd2,
    ST_NOT_READY = 3'd3,
    ST_READ_FAIL = 3'd4,
    ST_ADJUSTED  = 3'd5,
    ST_DONE      = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    LED_KEEP   = 2'd0,
    LED_OFF    = 2'd1,
    LED_TOGGLE = 2'd2,
    LED_SOLID  = 2'd3
  } led_e;

  typedef struct packed {
    logic [6:0]         cal_code;
    logic               batt_ready;
    logic signed [23:0] measured_current;
    logic               param_read_ok;
    logic [27:0]        param_value_in;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic               start_report;
    logic               stop_report;
    logic [2:0]         batt_sel;
    logic [3:0]         target_amps;
    logic [27:0]        param_write_value;
    logic signed [23:0] filtered_current;
    led_e               led_mode;
  } out_t;

  typedef struct packed {
    logic [6:0]         code;
    logic               code_ok;
    logic [2:0]         bidx;
    logic [3:0]         amps;
    logic               ready;
    logic               read_ok;
    logic signed [40:0] meas_prod;
    logic [15:0]        step;
    logic [27:0]        pin;
  } prep_t;

  function automatic logic code_is_valid(input logic [6:0] code);
    return code inside {[7'd10:7'd69]};
  endfunction

endpackage

`default_nettype wire

/* src/csac_prep.sv */
`default_nettype none

module csac_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  csac_pkg::in_t   in_data_i,
  input  logic            take_i,
  output logic            prep_valid_o,
  output csac_pkg::prep_t prep_o
);
  import csac_pkg::*;

  logic        valid_q;
  prep_t       prep_d, prep_q;
  logic [14:0] div_prod;
  logic [3:0]  quot;
  logic [6:0]  quot_x10;
  logic [47:0] step_prod;

  assign in_ready_o   = !valid_q || take_i;
  assign prep_valid_o = valid_q;
  assign prep_o       = prep_q;

  assign div_prod  = 15'(in_data_i.cal_code) * 15'(Div10Mul);
  assign quot      = 4'(div_prod >> Div10Shift);
  assign quot_x10  = 7'(quot) * 7'd10;
  assign step_prod = 48'(in_data_i.param_value_in) * 48'(StepQ32) + StepRound;

  always_comb begin
    prep_d.code      = in_data_i.cal_code;
    prep_d.code_ok   = code_is_valid(in_data_i.cal_code);
    prep_d.bidx      = '0;
    prep_d.amps      = '0;
    if (prep_d.code_ok) begin
      prep_d.bidx = 3'(quot - 4'd1);
      prep_d.amps = 4'(in_data_i.cal_code - quot_x10);
    end
    prep_d.ready     = in_data_i.batt_ready;
    prep_d.read_ok   = in_data_i.param_read_ok;
    prep_d.meas_prod = 41'(in_data_i.measured_current) * 41'(LpfNewQ16);
    prep_d.step      = step_prod[47:32];
    prep_d.pin       = in_data_i.param_value_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      prep_q <= prep_d;
    end
  end

endmodule

`default_nettype wire

/* src/current_sensor_autocalibrator_top.sv */
// Current sensor auto-calibrator. One input beat is one 100 ms tick and yields exactly one
// output beat. A beat passes an input register, where the code is decoded and the products
// that depend only on the tick are formed, then the filter, error sign, setting nudge and
// clamp logic that writes the result register. The block takes one beat per cycle while the
// output side drains, and a new beat is accepted while a result still waits on out_ready_i.
// The only loop is the filter and state update, closed through the state registers. The
// startup delay register is written through the cfg channel, which is always ready.
`default_nettype none

module current_sensor_autocalibrator_top #(
  parameter int unsigned CrossingLimit = csac_pkg::CROSSING_LIMIT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  csac_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output csac_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_data_i
);
  import csac_pkg::*;

  logic               prep_valid;
  prep_t              prep;
  logic               adv;

  logic [7:0]         delay_cfg_q;
  logic [6:0]         prev_code_q, prev_code_d;
  logic [7:0]         delay_q, delay_d;
  logic [3:0]         cross_q, cross_d;
  logic               sign_q, sign_d;
  logic signed [23:0] filt_q, filt_d;

  logic               out_valid_q;
  out_t               out_q, res;

  logic signed [41:0] filt_ext;
  logic signed [41:0] acc;
  logic signed [23:0] filt_new;
  logic               err_sign;
  logic [28:0]        p_adj, p_lo, p_hi, p_clamp;

  csac_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .take_i      (adv),
    .prep_valid_o(prep_valid),
    .prep_o      (prep)
  );

  assign adv         = prep_valid && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign filt_ext = 42'(filt_q);
  assign acc      = 42'(prep.meas_prod) + filt_ext * LpfOldQ16 + LpfRound;
  assign filt_new = acc[39:16];
  assign err_sign = ($signed({filt_new[23], filt_new}) >= $signed({5'b0, prep.amps, 16'b0}))
                    ^ (prep.amps == 4'd0);

  always_comb begin
    p_adj   = err_sign ? {1'b0, prep.pin} - 29'(prep.step) : {1'b0, prep.pin} + 29'(prep.step);
    p_lo    = (prep.amps == 4'd0) ? OffsetLo : ScaleLo;
    p_hi    = (prep.amps == 4'd0) ? OffsetHi : ScaleHi;
    p_clamp = p_adj;
    if (p_adj < p_lo) begin
      p_clamp = p_lo;
    end
    if (p_clamp > p_hi) begin
      p_clamp = p_hi;
    end
  end

  always_comb begin
    prev_code_d = prev_code_q;
    delay_d     = delay_q;
    cross_d     = cross_q;
    sign_d      = sign_q;
    filt_d      = filt_q;

    res.status            = ST_SKIPPED;
    res.start_report      = 1'b0;
    res.stop_report       = 1'b0;
    res.batt_sel          = prep.bidx;
    res.target_amps       = prep.amps;
    res.param_write_value = '0;
    res.led_mode          = LED_KEEP;

    if (delay_q != 8'd0) begin
      delay_d = delay_q - 8'd1;
    end else if (prep.code != prev_code_q) begin
      res.status      = ST_CHANGED;
      res.led_mode    = LED_OFF;
      cross_d         = '0;
      res.stop_report = code_is_valid(prev_code_q);
      if (prep.code_ok) begin
        res.start_report = 1'b1;
        delay_d          = delay_cfg_q;
      end
      prev_code_d = prep.code;
    end else if (!prep.code_ok) begin
      res.status = ST_INACTIVE;
    end else if (!prep.ready) begin
      res.status = ST_NOT_READY;
    end else if (!prep.read_ok) begin
      res.status = ST_READ_FAIL;
    end else begin
      filt_d                = filt_new;
      res.param_write_value = p_clamp[27:0];
      if (cross_q < 4'(CrossingLimit)) begin
        res.status   = ST_ADJUSTED;
        res.led_mode = LED_TOGGLE;
        if (sign_q != err_sign) begin
          sign_d  = err_sign;
          cross_d = cross_q + 4'd1;
        end
      end else begin
        res.status   = ST_DONE;
        res.led_mode = LED_SOLID;
      end
    end

    res.filtered_current = filt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_cfg_q <= StartupDelayReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      delay_cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_code_q <= '0;
      delay_q     <= '0;
      cross_q     <= '0;
      sign_q      <= 1'b0;
      filt_q      <= '0;
    end else if (adv) begin
      prev_code_q <= prev_code_d;
      delay_q     <= delay_d;
      cross_q     <= cross_d;
      sign_q      <= sign_d;
      filt_q      <= filt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

/* src/csac_checker.sv */
`default_nettype none

module csac_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input csac_pkg::out_t out_data_o
);
  import csac_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output side can drain");

  a_start_is_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.start_report |->
      out_data_o.status == ST_CHANGED && out_data_o.led_mode == LED_OFF)
    else $error("start report outside a code change");

  a_write_only_adjusted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_ADJUSTED && out_data_o.status != ST_DONE |->
      out_data_o.param_write_value == '0)
    else $error("setting written back without adjustment");

endmodule

bind current_sensor_autocalibrator_top csac_checker u_csac_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

/* tb/current_sensor_autocalibrator_top_test.sv */
`default_nettype none

module current_sensor_autocalibrator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import csac_pkg::*;

  typedef longint unsigned u64_t;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 50;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_TICKS = 180;
  localparam int unsigned CROSS_LIMIT = 10;
  localparam longint LPF_NEW = 62259;
  localparam longint LPF_OLD = 3277;
  localparam u64_t STEP_Q32 = 429497;
  localparam u64_t ONE_Q24 = 64'd16777216;
  localparam int AMP_Q16 = 65536;
  localparam int NOISE_Q16 = 98304;

  typedef struct {
    bit          is_cfg;
    logic [7:0]  cfg_val;
    in_t         stim;
    int unsigned reps;
    bit          flip;
    bit          typed;
    out_t        want;
  } dir_row_t;

  logic       clk;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  in_t        in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  logic [7:0]         delay_setting = StartupDelayReset;
  logic [6:0]         held_code = '0;
  logic [7:0]         settle_left = '0;
  logic [3:0]         crossings = '0;
  bit                 error_sign = 1'b0;
  logic signed [23:0] lpf_model = '0;

  out_t        pending_results[$];
  int unsigned n_err = 0;
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  int unsigned cyc_count = 0;
  int unsigned status_tally[7];
  int unsigned n_ticks = 0;
  dir_row_t    dir_tab[$];

  current_sensor_autocalibrator_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cyc_count <= cyc_count + 1;

  initial begin
    wait (cyc_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cyc_count,
             pending_results.size());
    $display("FAILURE");
    $finish;
  end

  function automatic bit code_in_range(input logic [6:0] code);
    return code >= 7'd10 && code <= 7'd69;
  endfunction

  function automatic out_t calibrate_tick(input in_t t);
    out_t   o;
    bit     code_ok;
    bit     sgn;
    longint acc;
    longint err;
    u64_t   d;
    u64_t   p;
    u64_t   lo;
    u64_t   hi;
    o = '0;
    o.status = ST_SKIPPED;
    o.led_mode = LED_KEEP;
    code_ok = code_in_range(t.cal_code);
    if (code_ok) begin
      o.batt_sel = 3'(t.cal_code / 10 - 1);
      o.target_amps = 4'(t.cal_code % 10);
    end
    if (settle_left != 0) begin
      settle_left = settle_left - 8'd1;
    end else if (t.cal_code != held_code) begin
      o.status = ST_CHANGED;
      o.led_mode = LED_OFF;
      crossings = '0;
      o.stop_report = code_in_range(held_code);
      if (code_ok) begin
        o.start_report = 1'b1;
        settle_left = delay_setting;
      end
      held_code = t.cal_code;
    end else if (!code_ok) begin
      o.status = ST_INACTIVE;
    end else if (!t.batt_ready) begin
      o.status = ST_NOT_READY;
    end else if (!t.param_read_ok) begin
      o.status = ST_READ_FAIL;
    end else begin
      acc = longint'($signed(t.measured_current)) * LPF_NEW
          + longint'(lpf_model) * LPF_OLD + 32768;
      lpf_model = 24'(acc >>> 16);
      err = longint'(lpf_model) - longint'(o.target_amps) * AMP_Q16;
      sgn = (err >= 0) != (o.target_amps == 0);
      d = (u64_t'(t.param_value_in) * STEP_Q32 + 64'h8000_0000) >> 32;
      p = sgn ? u64_t'(t.param_value_in) - d : u64_t'(t.param_value_in) + d;
      lo = (o.target_amps == 0) ? ONE_Q24 : 10 * ONE_Q24;
      hi = (o.target_amps == 0) ? 2 * ONE_Q24 : 13 * ONE_Q24;
      if (p < lo) p = lo;
      if (p > hi) p = hi;
      o.param_write_value = 28'(p);
      if (crossings < CROSS_LIMIT) begin
        o.status = ST_ADJUSTED;
        o.led_mode = LED_TOGGLE;
        if (error_sign != sgn) begin
          error_sign = sgn;
          crossings = crossings + 4'd1;
        end
      end else begin
        o.status = ST_DONE;
        o.led_mode = LED_SOLID;
      end
    end
    o.filtered_current = lpf_model;
    return o;
  endfunction

  task automatic report_field(input string fld, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      n_err++;
      if (n_err <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, fld, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        n_err++;
        if (n_err <= MAX_REPORTS)
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_data_o);
      end else begin
        want = pending_results.pop_front();
        report_field("status", want.status, out_data_o.status);
        report_field("start_report", want.start_report, out_data_o.start_report);
        report_field("stop_report", want.stop_report, out_data_o.stop_report);
        report_field("batt_sel", want.batt_sel, out_data_o.batt_sel);
        report_field("target_amps", want.target_amps, out_data_o.target_amps);
        report_field("param_write_value", want.param_write_value,
                     out_data_o.param_write_value);
        report_field("filtered_current", want.filtered_current,
                     out_data_o.filtered_current);
        report_field("led_mode", want.led_mode, out_data_o.led_mode);
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_pct);
  end

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_tick(input in_t t, input bit typed, input out_t want,
                           output out_t pred);
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_pct);
    end
    in_data_i <= t;
    in_valid_i <= 1'b1;
    do @(posedge clk); while (!in_ready_o);
    pred = calibrate_tick(t);
    pending_results.push_back(typed ? want : pred);
    status_tally[pred.status]++;
    n_ticks++;
  endtask

  task automatic write_delay(input logic [7:0] v);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    delay_setting = v;
  endtask

  function automatic dir_row_t mk_row(input bit is_cfg, input logic [7:0] cv, input in_t s,
                                      input int unsigned reps, input bit flip,
                                      input bit typed, input out_t w);
    dir_row_t r;
    r.is_cfg = is_cfg;
    r.cfg_val = cv;
    r.stim = s;
    r.reps = reps;
    r.flip = flip;
    r.typed = typed;
    r.want = w;
    return r;
  endfunction

  task automatic run_phase(input int unsigned budget);
    int unsigned counted;
    int unsigned kind;
    int unsigned len;
    logic [6:0]  code;
    logic [3:0]  amps;
    logic [27:0] setting;
    in_t         t;
    out_t        p;
    counted = 0;
    while (counted < budget) begin
      kind = $urandom_range(0, 9);
      amps = '0;
      if (kind < 7) begin
        code = 7'($urandom_range(10, 69));
        amps = 4'(code % 10);
        len = delay_setting + $urandom_range(4, 48);
      end else begin
        code = $urandom_range(0, 1) ? 7'($urandom_range(0, 9)) : 7'($urandom_range(70, 127));
        len = $urandom_range(1, 6);
      end
      if ($urandom_range(0, 7) == 0)
        setting = 28'($urandom);
      else if (amps == 0)
        setting = 28'($urandom_range(8388608, 41943040));
      else
        setting = 28'($urandom_range(150994944, 234881024));
      repeat (len) begin
        if (kind >= 8) begin
          t.cal_code = 7'($urandom);
          t.batt_ready = 1'($urandom);
          t.measured_current = 24'($urandom);
          t.param_read_ok = 1'($urandom);
          t.param_value_in = 28'($urandom);
        end else begin
          t.cal_code = code;
          t.batt_ready = ($urandom_range(0, 15) != 0);
          t.param_read_ok = ($urandom_range(0, 15) != 0);
          if ($urandom_range(0, 15) == 0)
            t.measured_current = 24'($urandom);
          else
            t.measured_current = 24'(int'(amps) * AMP_Q16
                                     + int'($urandom_range(0, 2 * NOISE_Q16)) - NOISE_Q16);
          t.param_value_in = setting;
        end
        send_tick(t, 1'b0, '0, p);
        if (p.status == ST_ADJUSTED || p.status == ST_DONE)
          setting = p.param_write_value;
        counted++;
      end
    end
  endtask

  initial begin
    logic [7:0]  ph_delay[NUM_PHASES];
    int unsigned ph_send[NUM_PHASES];
    int unsigned ph_recv[NUM_PHASES];
    in_t         s;
    out_t        p;

    foreach (status_tally[i]) status_tally[i] = 0;
    ph_delay = '{8'd255, 8'($urandom_range(1, 30)), 8'd0, 8'd19, 8'd1,
                 8'($urandom_range(2, 12)), 8'd0, 8'd3};
    ph_send = '{0, 53, 0, 31, 0, 53, 0, 31};
    ph_recv = '{0, 0, 53, 31, 0, 0, 53, 31};

    // after reset: code 0 is unchanged and invalid
    dir_tab.push_back(mk_row(0, 0, in_t'{7'd0, 1'b0, 24'sd0, 1'b0, 28'd0}, 1, 0, 1,
      out_t'{ST_INACTIVE, 1'b0, 1'b0, 3'd0, 4'd0, 28'd0, 24'sd0, LED_KEEP}));
    dir_tab.push_back(mk_row(0, 0,
      in_t'{7'd127, 1'b1, 24'sh7FFFFF, 1'b1, 28'hFFFFFFF}, 1, 0, 1,
      out_t'{ST_CHANGED, 1'b0, 1'b0, 3'd0, 4'd0, 28'd0, 24'sd0, LED_OFF}));
    dir_tab.push_back(mk_row(0, 0, in_t'{7'd69, 1'b1, 24'sd0, 1'b1, 28'd0}, 1, 0, 1,
      out_t'{ST_CHANGED, 1'b1, 1'b0, 3'd5, 4'd9, 28'd0, 24'sd0, LED_OFF}));
    // settle delay from the reset value ignores the code
    dir_tab.push_back(mk_row(0, 0,
      in_t'{7'd12, 1'b1, 24'sh800000, 1'b1, 28'hFFFFFFF}, 19, 0, 1,
      out_t'{ST_SKIPPED, 1'b0, 1'b0, 3'd0, 4'd2, 28'd0, 24'sd0, LED_KEEP}));
    dir_tab.push_back(mk_row(0, 0, in_t'{7'd69, 1'b0, 24'sd0, 1'b1, 28'd0}, 1, 0, 1,
      out_t'{ST_NOT_READY, 1'b0, 1'b0, 3'd5, 4'd9, 28'd0, 24'sd0, LED_KEEP}));
    dir_tab.push_back(mk_row(0, 0, in_t'{7'd69, 1'b1, 24'sd0, 1'b0, 28'd0}, 1, 0, 1,
      out_t'{ST_READ_FAIL, 1'b0, 1'b0, 3'd5, 4'd9, 28'd0, 24'sd0, LED_KEEP}));
    dir_tab.push_back(mk_row(0, 0, in_t'{7'd69, 1'b1, 24'sh7FFFFF, 1'b1, 28'd0},
      1, 0, 0, '0));
    dir_tab.push_back(mk_row(0, 0,
      in_t'{7'd69, 1'b1, 24'sh800000, 1'b1, 28'hFFFFFFF}, 1, 0, 0, '0));
    dir_tab.push_back(mk_row(1, 8'd0, '0, 0, 0, 0, '0));
    // offset calibration, stop and start together
    dir_tab.push_back(mk_row(0, 0, in_t'{7'd60, 1'b1, 24'sd0, 1'b1, 28'd100}, 1, 0, 0, '0));
    dir_tab.push_back(mk_row(0, 0, in_t'{7'd60, 1'b1, 24'sd65536, 1'b1, 28'd0},
      1, 0, 0, '0));
    // alternate the current to run past the crossing limit into done
    dir_tab.push_back(mk_row(0, 0,
      in_t'{7'd60, 1'b1, -24'sd65536, 1'b1, 28'hFFFFFFF}, 14, 1, 0, '0));
    dir_tab.push_back(mk_row(0, 0,
      in_t'{7'd59, 1'b1, 24'sd589824, 1'b1, 28'd16777216}, 1, 0, 0, '0));
    dir_tab.push_back(mk_row(0, 0,
      in_t'{7'd59, 1'b1, 24'sd589924, 1'b1, 28'd218103808}, 2, 0, 0, '0));
    dir_tab.push_back(mk_row(0, 0, in_t'{7'd5, 1'b1, 24'sd0, 1'b1, 28'd0}, 1, 0, 0, '0));
    dir_tab.push_back(mk_row(0, 0, in_t'{7'd70, 1'b1, 24'sd0, 1'b1, 28'd0}, 2, 0, 0, '0));
    dir_tab.push_back(mk_row(0, 0, in_t'{7'd10, 1'b1, 24'sd0, 1'b1, 28'd0}, 1, 0, 0, '0));

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_delay(dir_tab[i].cfg_val);
      end else begin
        for (int unsigned r = 0; r < dir_tab[i].reps; r++) begin
          s = dir_tab[i].stim;
          if (dir_tab[i].flip && r[0])
            s.measured_current = -s.measured_current;
          send_tick(s, dir_tab[i].typed, dir_tab[i].want, p);
        end
      end
    end

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      write_delay(ph_delay[ph]);
      send_pct = ph_send[ph];
      recv_pct = ph_recv[ph];
      run_phase(PHASE_TICKS);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d ticks over %0d delay settings plus reset value: %0d adjusted, %0d done,",
             n_ticks, NUM_PHASES + 1, status_tally[ST_ADJUSTED], status_tally[ST_DONE]);
    $display("  %0d code changes, %0d settle, %0d inactive, %0d not ready, %0d read fail",
             status_tally[ST_CHANGED], status_tally[ST_SKIPPED], status_tally[ST_INACTIVE],
             status_tally[ST_NOT_READY], status_tally[ST_READ_FAIL]);
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", n_err);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
